### rtl/rsem_pkg.sv
// Shared constants and types for the RGB Sobel edge magnitude core.
package rsem_pkg;
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int PW = 24;
    localparam int CFG_W = 12;
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef logic [PW-1:0] t_pix;

    // one result request towards the magnitude unit
    typedef struct packed {
        t_pix [8:0]  win;   // l0 l1 l2 m0 m1 m2 r0 r1 r2
        logic [10:0] row;
        logic [10:0] col;
        logic        last;
        logic        eof;
    } t_job;
endpackage

### rtl/rsem_linebuf.sv
// Dual line store memory, one row pair per column, with a registered read.
module rsem_linebuf (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [rsem_pkg::AW-1:0] i_waddr,
    input  logic [2*rsem_pkg::PW-1:0] i_wdata,
    input  logic                  i_re,
    input  logic [rsem_pkg::AW-1:0] i_raddr,
    output logic [2*rsem_pkg::PW-1:0] o_rdata
);
    logic [2*rsem_pkg::PW-1:0] r_mem [rsem_pkg::MAX_WIDTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        if (i_re) o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/rsem_mag.sv
// Sobel gradients and iterative capped integer square root for three channels.
module rsem_mag (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  rsem_pkg::t_job i_job,
    output logic          o_busy,
    output logic          o_done,
    output logic [23:0]   o_mag,
    output logic [10:0]   o_row,
    output logic [10:0]   o_col,
    output logic          o_last,
    output logic          o_eof
);
    typedef enum logic [1:0] {S_IDLE, S_SQ, S_ROOT} t_state;
    t_state r_state;
    logic [2:0][10:0] r_gx, r_gy;
    logic [2:0][16:0] r_s;
    logic [2:0][7:0]  r_root;
    logic [2:0]       r_sat;
    logic [7:0]       r_bit;
    logic [10:0]      r_row, r_col;
    logic             r_last, r_eof, r_done;

    logic [2:0][10:0] n_gx, n_gy;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_gx[k] = ({3'd0, i_job.win[8][k*8+:8]} + {2'd0, i_job.win[5][k*8+:8], 1'b0}
                     + {3'd0, i_job.win[2][k*8+:8]})
                    - ({3'd0, i_job.win[6][k*8+:8]} + {2'd0, i_job.win[3][k*8+:8], 1'b0}
                     + {3'd0, i_job.win[0][k*8+:8]});
            n_gy[k] = ({3'd0, i_job.win[8][k*8+:8]} + {2'd0, i_job.win[7][k*8+:8], 1'b0}
                     + {3'd0, i_job.win[6][k*8+:8]})
                    - ({3'd0, i_job.win[2][k*8+:8]} + {2'd0, i_job.win[1][k*8+:8], 1'b0}
                     + {3'd0, i_job.win[0][k*8+:8]});
        end
    end

    logic [2:0][7:0]  w_t;
    logic [2:0][15:0] w_tt;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_t[k]  = r_root[k] | r_bit;
            w_tt[k] = w_t[k] * w_t[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_start) begin
                    r_gx <= n_gx; r_gy <= n_gy;
                    r_row <= i_job.row; r_col <= i_job.col;
                    r_last <= i_job.last; r_eof <= i_job.eof;
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    for (int k = 0; k < 3; k++) begin
                        logic [21:0] sq;
                        sq = {{11{r_gx[k][10]}}, r_gx[k]} * {{11{r_gx[k][10]}}, r_gx[k]}
                           + {{11{r_gy[k][10]}}, r_gy[k]} * {{11{r_gy[k][10]}}, r_gy[k]};
                        r_s[k]   <= sq[16:0];
                        r_sat[k] <= |sq[21:16];
                        r_root[k] <= 8'd0;
                    end
                    r_bit   <= 8'h80;
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    for (int k = 0; k < 3; k++)
                        if ({1'b0, w_tt[k]} <= r_s[k]) r_root[k] <= w_t[k];
                    r_bit <= r_bit >> 1;
                    if (r_bit == 8'd1) begin
                        r_state <= S_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_row = r_row; assign o_col = r_col;
    assign o_last = r_last; assign o_eof = r_eof;
    always_comb
        for (int k = 0; k < 3; k++) o_mag[k*8+:8] = r_sat[k] ? 8'hFF : r_root[k];

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy) else $error("done while busy");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("start ignored");
    a_no_double: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("double done");
`endif
endmodule

### rtl/rgb_sobel_edge_magnitude_core.sv
// Top level: stream control, window, line store and result sequencing.
// Each result passes through issue, squaring and the bitwise root in the shared square-root
// unit, and the output transfer; a new input is taken only after every result that the last
// one causes (up to four at the last row) is transferred, so inputs also wait while m_axis_tready is low.
// Reset: synchronous active low; sizes to 640x480, position and window zero.
module rgb_sobel_edge_magnitude_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [11:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // pixel_red, pixel_green, pixel_blue
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // out_row, out_col, mag_red, mag_green, mag_blue, pad
    output logic        m_axis_tlast,   // last_of_run
    output logic        m_axis_tuser    // end_of_frame
);
    localparam int AW = rsem_pkg::AW;
    typedef enum logic [2:0] {S_IDLE, S_READ, S_ISSUE, S_WAIT, S_OUT, S_FIN} t_state;
    t_state r_state;

    logic [11:0] r_fw, r_fh;
    logic [10:0] r_row, r_col, r_w1, r_h1;
    rsem_pkg::t_pix r_now;
    rsem_pkg::t_pix [5:0] r_win;
    logic [1:0] r_k, r_n;
    logic [3:0] r_sel;
    logic r_hold;
    logic [47:0] r_data; logic r_last, r_eof;

    logic [47:0] w_rd;
    logic [11:0] w_w, w_h;
    assign w_w = (r_fw < 12'd2) ? 12'd2 : (r_fw > 12'(rsem_pkg::MAX_WIDTH)) ?
                 12'(rsem_pkg::MAX_WIDTH) : r_fw;
    assign w_h = (r_fh < 12'd2) ? 12'd2 : (r_fh > 12'(rsem_pkg::MAX_HEIGHT)) ?
                 12'(rsem_pkg::MAX_HEIGHT) : r_fh;

    wire w_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && !r_hold;

    rsem_linebuf u_lb (.i_clk, .i_we(r_state == S_FIN), .i_waddr(r_col[AW-1:0]),
        .i_wdata({w_rd[23:0], r_now}), .i_re(w_acc), .i_raddr(r_col[AW-1:0]),
        .o_rdata(w_rd));

    // column pixels: old(top), new, current
    rsem_pkg::t_pix w_o, w_n, w_c;
    assign w_o = w_rd[47:24]; assign w_n = w_rd[23:0]; assign w_c = r_now;
    wire w_c0 = (r_col == 11'd0);
    rsem_pkg::t_pix [2:0] w_a, w_b;  // window cols (b: 2 back, a: 1 back)
    assign w_a = w_c0 ? {w_c, w_n, w_o} : r_win[2:0];
    assign w_b = w_c0 ? {w_c, w_n, w_o} : r_win[5:3];

    // result kinds in order: bit0 upper c-1, bit1 upper edge, bit2 lower c-1, bit3 lower edge
    logic [1:0] w_kind;
    always_comb begin
        w_kind = r_sel[0] ? 2'd0 : r_sel[1] ? 2'd1 : r_sel[2] ? 2'd2 : 2'd3;
    end
    wire w_edge = w_kind[0];
    wire w_lower = w_kind[1];
    wire w_hasold = (r_row >= 11'd2);
    rsem_pkg::t_pix [2:0] w_lc, w_mc, w_rc;
    assign w_lc = w_edge ? w_a : w_b;
    assign w_mc = w_edge ? {w_c, w_n, w_o} : w_a;
    assign w_rc = {w_c, w_n, w_o};

    function automatic rsem_pkg::t_pix [2:0] pick(input rsem_pkg::t_pix [2:0] col,
                                                  input logic lower, input logic ho);
        rsem_pkg::t_pix [2:0] d;
        if (lower) d = {col[2], col[2], col[1]};
        else d = {col[2], col[1], ho ? col[0] : col[1]};
        return d;
    endfunction

    rsem_pkg::t_job w_job;
    always_comb begin
        w_job.win  = {pick(w_lc, w_lower, w_hasold), pick(w_mc, w_lower, w_hasold),
                      pick(w_rc, w_lower, w_hasold)};
        w_job.win  = {w_job.win[2:0], w_job.win[5:3], w_job.win[8:6]};
        w_job.row  = w_lower ? r_row : r_row - 11'd1;
        w_job.col  = w_edge ? r_w1 : r_col - 11'd1;
        w_job.last = (r_k == r_n);
        w_job.eof  = w_lower && w_edge;
    end

    logic w_busy, w_done, w_ml, w_me;
    logic [23:0] w_mag; logic [10:0] w_mr, w_mcol;
    rsem_mag u_mag (.i_clk, .i_rst_n, .i_start(r_state == S_ISSUE), .i_job(w_job),
        .o_busy(w_busy), .o_done(w_done), .o_mag(w_mag), .o_row(w_mr), .o_col(w_mcol),
        .o_last(w_ml), .o_eof(w_me));

    logic [3:0] w_s;
    assign w_s[0] = (r_row >= 11'd1) && !w_c0;
    assign w_s[1] = (r_row >= 11'd1) && (r_col == r_w1);
    assign w_s[2] = w_s[0] && (r_row == r_h1);
    assign w_s[3] = w_s[1] && (r_row == r_h1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_fw <= 12'd640; r_fh <= 12'd480;
            r_row <= '0; r_col <= '0; r_win <= '0; r_hold <= 1'b0;
            r_w1 <= 11'd639; r_h1 <= 11'd479;
        end else begin
            r_w1 <= 11'(w_w - 12'd1); r_h1 <= 11'(w_h - 12'd1);
            r_hold <= i_cfg_we;
            if (i_cfg_we) begin
                if (i_cfg_addr == rsem_pkg::CFG_WIDTH) r_fw <= i_cfg_data;
                else r_fh <= i_cfg_data;
                r_row <= '0; r_col <= '0;
            end
            unique case (r_state)
                S_IDLE: if (w_acc) begin
                    // held with red in the top byte
                    r_now <= {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_sel <= w_s;
                    r_n <= 2'($countones(w_s)) - 2'd1;
                    r_k <= 2'd0;
                    r_state <= (w_s == 4'd0) ? S_FIN : S_ISSUE;
                end
                S_ISSUE: r_state <= S_WAIT;
                S_WAIT: if (w_done) begin
                    r_data <= {2'b00, w_mag[7:0], w_mag[15:8], w_mag[23:16], w_mcol, w_mr};
                    r_last <= w_ml; r_eof <= w_me; r_state <= S_OUT;
                    r_sel[w_kind] <= 1'b0;
                end
                S_OUT: if (m_axis_tready) begin
                    r_k <= r_k + 2'd1;
                    r_state <= (r_sel == 4'd0) ? S_FIN : S_ISSUE;
                end
                S_FIN: begin
                    r_win <= {w_a, w_c, w_n, w_o};
                    if (r_col == r_w1) begin
                        r_col <= '0;
                        r_row <= (r_row == r_h1) ? 11'd0 : r_row + 11'd1;
                    end else r_col <= r_col + 11'd1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata = r_data;
    assign m_axis_tlast = r_last;
    assign m_axis_tuser = r_eof;

`ifndef SYNTHESIS
    a_no_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input during output");
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast) else $error("eof not last");
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_col <= r_w1 || $past(i_cfg_we) || $past(i_cfg_we, 2)))
        else $error("column out of range");
    a_issue_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ISSUE) |-> !w_busy) else $error("issue while root unit busy");
`endif
endmodule

### test/tb.sv
// Self-checking testbench for the RGB Sobel edge magnitude core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 2000000;
    localparam int SETTLE = 24;

    typedef struct packed {
        logic [10:0] row;
        logic [10:0] col;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        last;
        logic        eof;
    } t_mag;

    typedef struct {
        bit          cfg;
        logic [11:0] wd;
        logic [11:0] ht;
        logic [23:0] pix;   // red, green, blue from the top byte down
        bit          flat;  // uniform frame: every magnitude is zero
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_addr = rsem_pkg::CFG_WIDTH;
    logic [11:0] cfg_data = '0;
    logic        s_vld = 1'b0;
    logic [23:0] s_data = '0;
    logic        m_rdy = 1'b0;
    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire  [47:0] m_axis_tdata;
    wire         m_axis_tlast;
    wire         m_axis_tuser;

    rgb_sobel_edge_magnitude_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_data(cfg_data),
        .s_axis_tvalid(s_vld), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_data),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_rdy),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    // predictor state
    logic [11:0]     fr_w = 12'd640;
    logic [11:0]     fr_h = 12'd480;
    rsem_pkg::t_pix  store_old [rsem_pkg::MAX_WIDTH];
    rsem_pkg::t_pix  store_new [rsem_pkg::MAX_WIDTH];
    rsem_pkg::t_pix  win [6];
    int              cur_row = 0;
    int              cur_col = 0;

    t_mag mag_q[$];
    int   errs = 0;
    int   cyc = 0;
    bit   no_idle = 0;

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int clamp_sz(logic [11:0] v, int hi);
        if (v < 2) return 2;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [7:0] root_cap(int s);
        int rt;
        int t;
        rt = 0;
        if (s >= 65536) return 8'd255;
        for (int b = 128; b != 0; b >>= 1) begin
            t = rt + b;
            if (t * t <= s) rt = t;
        end
        return rt[7:0];
    endfunction

    // columns as top, middle, bottom
    function automatic logic [7:0] grad(rsem_pkg::t_pix l[3], rsem_pkg::t_pix m[3],
                                        rsem_pkg::t_pix r[3], int sh);
        int gx;
        int gy;
        gx = (int'(l[0][sh+:8]) + 2 * int'(m[0][sh+:8]) + int'(r[0][sh+:8]))
           - (int'(l[2][sh+:8]) + 2 * int'(m[2][sh+:8]) + int'(r[2][sh+:8]));
        gy = (int'(l[0][sh+:8]) + 2 * int'(l[1][sh+:8]) + int'(l[2][sh+:8]))
           - (int'(r[0][sh+:8]) + 2 * int'(r[1][sh+:8]) + int'(r[2][sh+:8]));
        return root_cap(gx * gx + gy * gy);
    endfunction

    // column given as older, newer, current; the last row repeats its bottom
    function automatic void row_view(rsem_pkg::t_pix c[3], bit lower, bit has_old,
                                     output rsem_pkg::t_pix d[3]);
        if (lower) begin
            d[0] = c[1]; d[1] = c[2]; d[2] = c[2];
        end else begin
            d[0] = has_old ? c[0] : c[1]; d[1] = c[1]; d[2] = c[2];
        end
    endfunction

    task automatic push_mag(int row, int col, rsem_pkg::t_pix lc[3], rsem_pkg::t_pix mc[3],
                            rsem_pkg::t_pix rc[3], bit lower, bit has_old, bit eof);
        rsem_pkg::t_pix l[3];
        rsem_pkg::t_pix m[3];
        rsem_pkg::t_pix r[3];
        t_mag e;
        row_view(lc, lower, has_old, l);
        row_view(mc, lower, has_old, m);
        row_view(rc, lower, has_old, r);
        e.row = row[10:0];
        e.col = col[10:0];
        e.red = grad(l, m, r, 16);
        e.green = grad(l, m, r, 8);
        e.blue = grad(l, m, r, 0);
        e.last = 1'b0;
        e.eof = eof;
        mag_q.push_back(e);
    endtask

    task automatic predict_pixel(rsem_pkg::t_pix p);
        int             w;
        int             h;
        int             r;
        int             c;
        int             n0;
        bit             has_old;
        rsem_pkg::t_pix now[3];
        rsem_pkg::t_pix wl[3];
        rsem_pkg::t_pix wm[3];
        w = clamp_sz(fr_w, rsem_pkg::MAX_WIDTH);
        h = clamp_sz(fr_h, rsem_pkg::MAX_HEIGHT);
        r = cur_row;
        c = cur_col;
        n0 = mag_q.size();
        has_old = (r >= 2);
        if (c >= w) c = 0;
        if (r >= h) r = 0;
        now[0] = store_old[c];
        now[1] = store_new[c];
        now[2] = p;
        if (c == 0) begin
            for (int i = 0; i < 3; i++) begin
                win[i] = now[i];
                win[i+3] = now[i];
            end
        end
        for (int i = 0; i < 3; i++) begin
            wm[i] = win[i];
            wl[i] = win[i+3];
        end
        if (r >= 1) begin
            if (c >= 1) push_mag(r - 1, c - 1, wl, wm, now, 0, has_old, 0);
            if (c == w - 1) push_mag(r - 1, w - 1, wm, now, now, 0, has_old, 0);
            if (r == h - 1) begin
                if (c >= 1) push_mag(r, c - 1, wl, wm, now, 1, has_old, 0);
                if (c == w - 1) push_mag(r, w - 1, wm, now, now, 1, has_old, 1);
            end
        end
        if (mag_q.size() > n0) mag_q[mag_q.size()-1].last = 1'b1;
        store_old[c] = now[1];
        store_new[c] = now[2];
        for (int i = 0; i < 3; i++) begin
            win[i+3] = win[i];
            win[i] = now[i];
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        cur_row = r;
        cur_col = c;
    endtask

    // p is red, green, blue from the top byte; the bus carries red lowest
    task automatic send_pixel(rsem_pkg::t_pix p, bit flat);
        int gap;
        int n0;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_vld <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_vld <= 1'b1;
        s_data <= {p[7:0], p[15:8], p[23:16]};
        n0 = mag_q.size();
        predict_pixel(p);
        if (flat) begin
            for (int i = n0; i < mag_q.size(); i++) begin
                mag_q[i].red = 8'd0;
                mag_q[i].green = 8'd0;
                mag_q[i].blue = 8'd0;
            end
        end
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic settle();
        s_vld <= 1'b0;
        @(posedge i_clk);
        while (mag_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic a, logic [11:0] v);
        cfg_we <= 1'b1;
        cfg_addr <= a;
        cfg_data <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (a == rsem_pkg::CFG_WIDTH) fr_w = v;
        else fr_h = v;
        cur_row = 0;
        cur_col = 0;
    endtask

    task automatic set_size(logic [11:0] wd, logic [11:0] ht);
        settle();
        write_reg(rsem_pkg::CFG_WIDTH, wd);
        write_reg(rsem_pkg::CFG_HEIGHT, ht);
    endtask

    function automatic rsem_pkg::t_pix rand_pixel();
        rsem_pkg::t_pix p;
        p = $urandom();
        if ($urandom_range(0, 3) == 0) begin
            for (int i = 0; i < 3; i++) p[8*i+:8] = $urandom_range(0, 1) ? 8'hff : 8'h00;
        end
        return p;
    endfunction

    // result side
    initial begin
        t_mag got;
        t_mag want;
        int gap;
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                m_rdy <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_rdy <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            got.row = m_axis_tdata[10:0];
            got.col = m_axis_tdata[21:11];
            got.red = m_axis_tdata[29:22];
            got.green = m_axis_tdata[37:30];
            got.blue = m_axis_tdata[45:38];
            got.last = m_axis_tlast;
            got.eof = m_axis_tuser;
            if (mag_q.size() == 0) begin
                errs++;
                if (errs <= 10) $display("unexpected transfer %p", got);
            end else begin
                want = mag_q.pop_front();
                if (got != want) begin
                    errs++;
                    if (errs <= 10) $display("mismatch exp %p got %p", want, got);
                end
            end
        end
    end

    t_row dir_tab[] = '{
        // reset sizes: only part of the first row, nothing comes out
        '{0, 0, 0, 24'h000000, 0}, '{0, 0, 0, 24'hffffff, 0}, '{0, 0, 0, 24'h123456, 0},
        '{1, 12'd2, 12'd2, 0, 0},
        '{0, 0, 0, 24'hffffff, 1}, '{0, 0, 0, 24'hffffff, 1},
        '{0, 0, 0, 24'hffffff, 1}, '{0, 0, 0, 24'hffffff, 1},
        // checkerboard, saturating the root
        '{0, 0, 0, 24'hffffff, 0}, '{0, 0, 0, 24'h000000, 0},
        '{0, 0, 0, 24'h000000, 0}, '{0, 0, 0, 24'hffffff, 0},
        // sizes below two clamp up
        '{1, 12'd0, 12'd1, 0, 0},
        '{0, 0, 0, 24'hff0000, 0}, '{0, 0, 0, 24'h00ff00, 0},
        '{0, 0, 0, 24'h0000ff, 0}, '{0, 0, 0, 24'h80807f, 0},
        '{1, 12'd3, 12'd3, 0, 0},
        '{0, 0, 0, 24'h010203, 0}, '{0, 0, 0, 24'hff00ff, 0}, '{0, 0, 0, 24'h00ff00, 0},
        '{0, 0, 0, 24'hfefefe, 0}, '{0, 0, 0, 24'h000000, 0}, '{0, 0, 0, 24'h7f7f7f, 0},
        '{0, 0, 0, 24'hffffff, 0}, '{0, 0, 0, 24'h55aa55, 0}, '{0, 0, 0, 24'haa55aa, 0}
    };

    initial begin
        int wd;
        int ht;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].cfg) set_size(dir_tab[i].wd, dir_tab[i].ht);
            else send_pixel(dir_tab[i].pix, dir_tab[i].flat);
        end

        // widest row, clamped from the top of the register range, partly sent
        set_size(12'd4095, 12'd2);
        no_idle = 1;
        repeat (64) send_pixel(rand_pixel(), 0);
        no_idle = 0;
        repeat (6) send_pixel(rand_pixel(), 0);

        // tallest frame, partly sent
        set_size(12'd2, 12'd4095);
        repeat (8) send_pixel(rand_pixel(), 0);

        // random frames, mostly complete
        for (int f = 0; f < 8; f++) begin
            wd = $urandom_range(2, 7);
            ht = $urandom_range(2, 5);
            set_size(wd[11:0], ht[11:0]);
            no_idle = (f % 5 == 4);
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, wd * ht)) send_pixel(rand_pixel(), 0);
            end else begin
                repeat (wd * ht * $urandom_range(1, 2)) send_pixel(rand_pixel(), 0);
            end
        end
        no_idle = 0;

        settle();
        if (errs == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
